[src/tedq_pkg.sv]
`default_nettype none

package tedq_pkg;

    localparam int QUEUE_DEPTH  = 32;
    localparam int TIME_BITS    = 48;

    localparam int TAG_W        = 16;
    localparam int FIELD_TIME_W = 48;
    localparam int COUNT_OUT_W  = 6;

    localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = TIME_BITS + TAG_W;

    typedef logic [TIME_BITS-1:0] stamp_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [TAG_W-1:0]     tag_t;

    typedef enum logic {
        OP_POST = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef struct packed {
        stamp_t due;
        tag_t   tag;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic post_start;
        logic tick_start;
        logic rd_below;
        logic shift;
        logic insert;
        logic rd_head;
        logic pop;
        logic emit;
        logic emit_has;
        logic emit_last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic one_left;
        logic scan_last;
        logic has_pend;
        logic hit;
        logic later;
        logic out_free;
    } stat_t;

    function automatic idx_t idx_inc(input idx_t i);
        return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx_t'(i + IDX_W'(1));
    endfunction

    function automatic idx_t idx_dec(input idx_t i);
        return (i == '0) ? IDX_W'(QUEUE_DEPTH - 1) : idx_t'(i - IDX_W'(1));
    endfunction

    // Slot just past the newest entry of the circular store.
    function automatic idx_t idx_add(input idx_t i, input cnt_t n);
        logic [IDX_W:0] s;
        s = (IDX_W+1)'(i) + (IDX_W+1)'(n);
        if (s >= (IDX_W+1)'(QUEUE_DEPTH))
        begin
            s = s - (IDX_W+1)'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic stamp_t to_stamp(input logic [FIELD_TIME_W-1:0] v);
        logic [TIME_BITS+FIELD_TIME_W-1:0] wide;
        wide = (TIME_BITS+FIELD_TIME_W)'(v);
        return wide[TIME_BITS-1:0];
    endfunction

    function automatic stamp_t sat_add(input stamp_t a, input stamp_t b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

[src/timed_event_delay_queue.sv]
`default_nettype none

// Channel   Handshake                   Payload
// -------   -------------------------   ------------------------------------------------
// item      item_valid / item_ready     operation, event_tag, delay, current_time
// result    result_valid / result_ready has_event, released_tag, released_count,
//                                       dropped, last
//
// One item at a time; the single read port of the entry store sets the pace. A post reads
// the newest entry, moves up a slot each pending entry that is due at or after the new
// one, writes the new entry into the gap and hands over its result; it writes at once on
// an empty store and only reports the drop on a full one. A tick releases due entries
// from the head one by one and marks the last; with nothing due it reports no event. Reset
// empties the store at once. A stalled result channel holds the controller only where it
// has a result to hand over; a new item is accepted while the previous final result waits.

module timed_event_delay_queue (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   item_valid,
    output logic                                        item_ready,
    input  wire logic                                   operation,
    input  wire logic [tedq_pkg::TAG_W-1:0]             event_tag,
    input  wire logic [tedq_pkg::FIELD_TIME_W-1:0]      delay,
    input  wire logic [tedq_pkg::FIELD_TIME_W-1:0]      current_time,
    output logic                                        result_valid,
    input  wire logic                                   result_ready,
    output logic                                        has_event,
    output logic      [tedq_pkg::TAG_W-1:0]             released_tag,
    output logic      [tedq_pkg::COUNT_OUT_W-1:0]       released_count,
    output logic                                        dropped,
    output logic                                        last
);

    import tedq_pkg::*;

    // The store is a circular buffer kept in due-time order from its head. A post walks
    // down from the newest entry, moving later entries up, and drops the new item into
    // the gap, so equal due times put the newest nearest the head. A tick pops the head
    // while it is due; each release is held back one step so that the last one can be
    // marked once the next entry is known not to be due.
    cmd_t  cmd;
    stat_t stat;

    tedq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .operation  (operation),
        .stat       (stat),
        .cmd        (cmd)
    );

    tedq_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .event_tag      (event_tag),
        .delay          (delay),
        .current_time   (current_time),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .has_event      (has_event),
        .released_tag   (released_tag),
        .released_count (released_count),
        .dropped        (dropped),
        .last           (last)
    );

endmodule

`default_nettype wire

[src/tedq_ram.sv]
`default_nettype none

module tedq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic                                      rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/tedq_ctrl.sv]
`default_nettype none

module tedq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_ready,
    input  wire logic           operation,
    input  wire tedq_pkg::stat_t stat,
    output tedq_pkg::cmd_t      cmd
);

    import tedq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_POST_READ  = 7'b0000010,
        S_POST_SCAN  = 7'b0000100,
        S_POST_WRITE = 7'b0001000,
        S_EMIT_DONE  = 7'b0010000,
        S_TICK_EVAL  = 7'b0100000,
        S_TICK_FLUSH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_TICK)
                    begin
                        cmd.tick_start = 1'b1;
                        if (stat.empty)
                        begin
                            state_next = S_EMIT_DONE;
                        end
                        else
                        begin
                            cmd.rd_head = 1'b1;
                            state_next  = S_TICK_EVAL;
                        end
                    end
                    else
                    begin
                        cmd.post_start = 1'b1;
                        if (stat.full)
                        begin
                            state_next = S_EMIT_DONE;
                        end
                        else if (stat.empty)
                        begin
                            state_next = S_POST_WRITE;
                        end
                        else
                        begin
                            state_next = S_POST_READ;
                        end
                    end
                end
            end
            S_POST_READ:
            begin
                cmd.rd_below = 1'b1;
                state_next   = S_POST_SCAN;
            end
            S_POST_SCAN:
            begin
                // Entries due at or after the new one move up by a slot.
                if (stat.later)
                begin
                    cmd.shift = 1'b1;
                    if (stat.scan_last)
                    begin
                        state_next = S_POST_WRITE;
                    end
                end
                else
                begin
                    state_next = S_POST_WRITE;
                end
            end
            S_POST_WRITE:
            begin
                cmd.insert = 1'b1;
                state_next = S_EMIT_DONE;
            end
            S_EMIT_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_TICK_EVAL:
            begin
                if (stat.hit)
                begin
                    // A held release goes out only when the next one is known to follow.
                    if (!stat.has_pend || stat.out_free)
                    begin
                        if (stat.has_pend)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_has = 1'b1;
                        end
                        cmd.pop = 1'b1;
                        if (stat.one_left)
                        begin
                            state_next = S_TICK_FLUSH;
                        end
                    end
                end
                else if (stat.has_pend)
                begin
                    state_next = S_TICK_FLUSH;
                end
                else
                begin
                    state_next = S_EMIT_DONE;
                end
            end
            S_TICK_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_has  = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[src/tedq_dp.sv]
`default_nettype none

module tedq_dp (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire tedq_pkg::cmd_t                         cmd,
    output tedq_pkg::stat_t                             stat,
    input  wire logic [tedq_pkg::TAG_W-1:0]             event_tag,
    input  wire logic [tedq_pkg::FIELD_TIME_W-1:0]      delay,
    input  wire logic [tedq_pkg::FIELD_TIME_W-1:0]      current_time,
    output logic                                        result_valid,
    input  wire logic                                   result_ready,
    output logic                                        has_event,
    output logic      [tedq_pkg::TAG_W-1:0]             released_tag,
    output logic      [tedq_pkg::COUNT_OUT_W-1:0]       released_count,
    output logic                                        dropped,
    output logic                                        last
);

    import tedq_pkg::*;

    idx_t   head_reg, head_next;
    cnt_t   count_reg, count_next;
    stamp_t last_tick_reg, last_tick_next;
    idx_t   slot_reg, slot_next;
    cnt_t   scan_reg, scan_next;
    idx_t   rd_idx_reg, rd_idx_next;
    stamp_t due_reg, due_next;
    tag_t   tag_reg, tag_next;
    stamp_t now_reg, now_next;
    cnt_t   rel_reg, rel_next;
    tag_t   pend_tag_reg, pend_tag_next;
    logic   drop_reg, drop_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   has_event_reg, has_event_next;
    tag_t                   rel_tag_reg, rel_tag_next;
    logic [COUNT_OUT_W-1:0] rel_cnt_reg, rel_cnt_next;
    logic                   dropped_reg, dropped_next;
    logic                   last_reg, last_next;

    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
    logic   rd_en;
    idx_t   rd_addr;
    entry_t rd_data;
    logic [ENTRY_W-1:0] rd_bits;

    tedq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_bits)
    );

    assign rd_data = rd_bits;

    always_comb
    begin
        rd_en   = cmd.rd_head || cmd.rd_below || cmd.shift || cmd.pop;
        rd_addr = head_reg;
        if (cmd.rd_below)
        begin
            rd_addr = idx_dec(slot_reg);
        end
        else if (cmd.shift)
        begin
            rd_addr = idx_dec(rd_idx_reg);
        end
        else if (cmd.pop)
        begin
            rd_addr = idx_inc(head_reg);
        end

        wr_en   = cmd.shift || cmd.insert;
        wr_addr = slot_reg;
        wr_data = cmd.shift ? rd_data : entry_t'{due: due_reg, tag: tag_reg};
    end

    always_comb
    begin
        stat.full      = (count_reg == CNT_W'(QUEUE_DEPTH));
        stat.empty     = (count_reg == '0);
        stat.one_left  = (count_reg == CNT_W'(1));
        stat.scan_last = (scan_reg == CNT_W'(1));
        stat.has_pend  = (rel_reg != '0);
        stat.hit       = (rd_data.due <= now_reg);
        stat.later     = (rd_data.due >= due_reg);
        stat.out_free  = !out_valid_reg || result_ready;
    end

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        last_tick_next = last_tick_reg;
        slot_next      = slot_reg;
        scan_next      = scan_reg;
        rd_idx_next    = rd_en ? rd_addr : rd_idx_reg;
        due_next       = due_reg;
        tag_next       = tag_reg;
        now_next       = now_reg;
        rel_next       = rel_reg;
        pend_tag_next  = pend_tag_reg;
        drop_next      = drop_reg;

        if (cmd.post_start)
        begin
            due_next  = sat_add(last_tick_reg, to_stamp(delay));
            tag_next  = event_tag;
            slot_next = idx_add(head_reg, count_reg);
            scan_next = count_reg;
            drop_next = (count_reg == CNT_W'(QUEUE_DEPTH));
        end
        if (cmd.tick_start)
        begin
            now_next       = to_stamp(current_time);
            last_tick_next = to_stamp(current_time);
            rel_next       = '0;
            drop_next      = 1'b0;
        end
        if (cmd.shift)
        begin
            slot_next = rd_idx_reg;
            scan_next = scan_reg - CNT_W'(1);
        end
        if (cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.pop)
        begin
            head_next     = idx_inc(head_reg);
            count_next    = count_reg - CNT_W'(1);
            rel_next      = rel_reg + CNT_W'(1);
            pend_tag_next = rd_data.tag;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !result_ready;
        has_event_next = has_event_reg;
        rel_tag_next   = rel_tag_reg;
        rel_cnt_next   = rel_cnt_reg;
        dropped_next   = dropped_reg;
        last_next      = last_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            has_event_next = cmd.emit_has;
            rel_tag_next   = cmd.emit_has ? pend_tag_reg : '0;
            rel_cnt_next   = cmd.emit_has ? COUNT_OUT_W'(rel_reg) : '0;
            dropped_next   = cmd.emit_has ? 1'b0 : drop_reg;
            last_next      = cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            last_tick_reg <= '0;
            rel_reg       <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            last_tick_reg <= last_tick_next;
            rel_reg       <= rel_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        scan_reg      <= scan_next;
        rd_idx_reg    <= rd_idx_next;
        due_reg       <= due_next;
        tag_reg       <= tag_next;
        now_reg       <= now_next;
        pend_tag_reg  <= pend_tag_next;
        has_event_reg <= has_event_next;
        rel_tag_reg   <= rel_tag_next;
        rel_cnt_reg   <= rel_cnt_next;
        dropped_reg   <= dropped_next;
        last_reg      <= last_next;
    end

    assign result_valid   = out_valid_reg;
    assign has_event      = has_event_reg;
    assign released_tag   = rel_tag_reg;
    assign released_count = rel_cnt_reg;
    assign dropped        = dropped_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

[sim/tedq_checker.sv]
`default_nettype none

module tedq_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    input  wire logic                               item_ready,
    input  wire logic                               operation,
    input  wire logic [tedq_pkg::TAG_W-1:0]         event_tag,
    input  wire logic [tedq_pkg::FIELD_TIME_W-1:0]  delay,
    input  wire logic [tedq_pkg::FIELD_TIME_W-1:0]  current_time,
    input  wire logic                               result_valid,
    input  wire logic                               result_ready,
    input  wire logic                               has_event,
    input  wire logic [tedq_pkg::TAG_W-1:0]         released_tag,
    input  wire logic [tedq_pkg::COUNT_OUT_W-1:0]   released_count,
    input  wire logic                               dropped,
    input  wire logic                               last,
    output int                                      fail_count,
    output int                                      owed_count
);

    timeunit 1ns;
    timeprecision 1ps;

    import tedq_pkg::*;

    typedef struct {
        logic                   has;
        tag_t                   tag;
        logic [COUNT_OUT_W-1:0] count;
        logic                   drop;
        logic                   fin;
    } release_rec_t;

    // Pending events, earliest due first, and the time of the latest tick.
    entry_t       timeline[$];
    stamp_t       prev_tick = '0;
    release_rec_t owed_results[$];

    initial
    begin
        fail_count = 0;
        owed_count = 0;
    end

    function automatic release_rec_t make_rec(input logic has, input tag_t tag,
                                              input int count, input logic drop,
                                              input logic fin);
        release_rec_t r;
        r.has   = has;
        r.tag   = tag;
        r.count = COUNT_OUT_W'(count);
        r.drop  = drop;
        r.fin   = fin;
        return r;
    endfunction

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [TAG_W-1:0] got,
                               input logic [TAG_W-1:0] want);
        if (got !== want)
        begin
            report($sformatf("%s is %0h, should be %0h", name, got, want));
        end
    endtask

    task automatic apply_post(input tag_t tag, input stamp_t dly);
        logic [TIME_BITS:0] sum;
        stamp_t             due;
        entry_t             e;
        int                 pos;
        if (timeline.size() >= QUEUE_DEPTH)
        begin
            owed_results.push_back(make_rec(1'b0, '0, 0, 1'b1, 1'b1));
            return;
        end
        sum = {1'b0, prev_tick} + {1'b0, dly};
        due = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
        // The newest event goes ahead of every entry with an equal or later due time.
        pos = 0;
        while (pos < timeline.size() && timeline[pos].due < due)
        begin
            pos++;
        end
        e.due = due;
        e.tag = tag;
        timeline.insert(pos, e);
        owed_results.push_back(make_rec(1'b0, '0, 0, 1'b0, 1'b1));
    endtask

    task automatic apply_tick(input stamp_t now);
        entry_t head;
        int     n;
        n = 0;
        while (timeline.size() > 0 && timeline[0].due <= now)
        begin
            head = timeline.pop_front();
            n++;
            owed_results.push_back(make_rec(1'b1, head.tag, n, 1'b0, 1'b0));
        end
        if (n == 0)
        begin
            owed_results.push_back(make_rec(1'b0, '0, 0, 1'b0, 1'b1));
        end
        else
        begin
            owed_results[owed_results.size() - 1].fin = 1'b1;
        end
        prev_tick = now;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        release_rec_t want;
        if (!rst_n)
        begin
            timeline.delete();
            owed_results.delete();
            prev_tick = '0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    report("result arrived with nothing pending");
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("has_event", TAG_W'(has_event), TAG_W'(want.has));
                    check_field("released_tag", released_tag, want.tag);
                    check_field("released_count", TAG_W'(released_count),
                                TAG_W'(want.count));
                    check_field("dropped", TAG_W'(dropped), TAG_W'(want.drop));
                    check_field("last", TAG_W'(last), TAG_W'(want.fin));
                end
            end
            if (item_valid && item_ready)
            begin
                if (operation == OP_TICK)
                begin
                    apply_tick(stamp_t'(current_time));
                end
                else
                begin
                    apply_post(event_tag, stamp_t'(delay));
                end
            end
        end
        owed_count <= owed_results.size();
    end

endmodule

`default_nettype wire

[sim/tb_top.sv]
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tedq_pkg::*;

    // Roughly how many items the run sends in total.
    localparam int ITEM_TARGET = 450;
    // The limit leaves a wide margin over the worst case per item (gap, 32
    // released events each waiting out a full stall).
    localparam int CYCLE_LIMIT = 1_000_000;
    // The tail outlasts a post that moves every entry of the store.
    localparam int TAIL_CYCLES = 80;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    item_valid   = 1'b0;
    logic                    item_ready;
    logic                    operation    = 1'b0;
    logic [TAG_W-1:0]        event_tag    = '0;
    logic [FIELD_TIME_W-1:0] delay        = '0;
    logic [FIELD_TIME_W-1:0] current_time = '0;
    logic                    result_valid;
    logic                    result_ready = 1'b0;
    logic                    has_event;
    logic [TAG_W-1:0]        released_tag;
    logic [COUNT_OUT_W-1:0]  released_count;
    logic                    dropped;
    logic                    last;

    int                      fail_count;
    int                      owed_count;
    int                      cycle_count  = 0;
    int                      items_sent   = 0;
    // While set, neither side inserts idle cycles.
    bit                      quiet        = 1'b0;
    // The time carried by the most recent tick that was sent.
    logic [FIELD_TIME_W-1:0] sent_time    = '0;

    always #1 clk = ~clk;

    timed_event_delay_queue u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .operation      (operation),
        .event_tag      (event_tag),
        .delay          (delay),
        .current_time   (current_time),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .has_event      (has_event),
        .released_tag   (released_tag),
        .released_count (released_count),
        .dropped        (dropped),
        .last           (last)
    );

    // The checker watches both channels, keeps its own sorted copy of the
    // pending events and compares every result as it is accepted.
    tedq_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .operation      (operation),
        .event_tag      (event_tag),
        .delay          (delay),
        .current_time   (current_time),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .has_event      (has_event),
        .released_tag   (released_tag),
        .released_count (released_count),
        .dropped        (dropped),
        .last           (last),
        .fail_count     (fail_count),
        .owed_count     (owed_count)
    );

    // A hung block ends the run here instead of running forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic logic [FIELD_TIME_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[FIELD_TIME_W-1:0];
    endfunction

    // Tags lean on the all-zero and all-one patterns now and then.
    function automatic tag_t pick_tag();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return '0;
        end
        if (r == 1)
        begin
            return '1;
        end
        return tag_t'($urandom());
    endfunction

    // Mostly short delays so that ticks release a few events at a time, with
    // full-width and maximum delays mixed in to reach saturation. Mode 3
    // crowds the due times together to exercise the order among equal ones.
    function automatic logic [FIELD_TIME_W-1:0] pick_delay(input int mode);
        int r;
        if (mode == 3)
        begin
            return FIELD_TIME_W'($urandom_range(0, 2));
        end
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return FIELD_TIME_W'($urandom_range(0, 40));
        end
        if (r < 80)
        begin
            return rand48();
        end
        if (r < 88)
        begin
            return '1;
        end
        return FIELD_TIME_W'($urandom_range(0, 3));
    endfunction

    // Time usually moves forward a little, but it may also jump anywhere,
    // stand still, drop back to zero or hit the maximum.
    function automatic logic [FIELD_TIME_W-1:0] pick_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return sent_time + FIELD_TIME_W'($urandom_range(0, 30));
        end
        if (r < 80)
        begin
            return rand48();
        end
        if (r < 87)
        begin
            return '1;
        end
        if (r < 92)
        begin
            return '0;
        end
        return sent_time;
    endfunction

    // Hands one item to the block. Valid stays high straight into the next
    // item when no gap is drawn, so it is only lowered when a gap follows.
    task automatic send_item(input op_t op, input tag_t tag,
                             input logic [FIELD_TIME_W-1:0] dly,
                             input logic [FIELD_TIME_W-1:0] now);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operation    <= op;
        event_tag    <= tag;
        delay        <= dly;
        current_time <= now;
        item_valid   <= 1'b1;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        if (op == OP_TICK)
        begin
            sent_time = now;
        end
        items_sent++;
    endtask

    // The field that an operation does not use carries random bits.
    task automatic post(input tag_t tag, input logic [FIELD_TIME_W-1:0] dly);
        send_item(OP_POST, tag, dly, rand48());
    endtask

    task automatic tick(input logic [FIELD_TIME_W-1:0] now);
        send_item(OP_TICK, tag_t'($urandom()), rand48(), now);
    endtask

    // The result side draws a stall before each result it takes, then holds
    // ready high until one is accepted.
    initial
    begin
        int gap;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
            begin
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int mode;
        int len;
        int post_share;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A tick on the empty store releases nothing.
        tick('0);
        // Smallest and largest tags and delays, then two events with equal
        // due times: the later one must come out first.
        post(16'h0000, '0);
        post(16'hFFFF, '1);
        post(16'h1234, 48'd10);
        post(16'h5678, 48'd10);
        tick(48'd10);
        // Close to the top of the time range nothing is due yet.
        tick(48'hFFFF_FFFF_FF00);
        // This due time overflows and saturates at the maximum, landing
        // ahead of the event that is already due there.
        post(16'hAAAA, 48'h1000);
        post(16'h5555, '0);
        tick('1);
        // Back to time zero, on an empty store again.
        tick('0);

        // Overfill the store so that the last posts are dropped, then release
        // whatever has become due.
        repeat (QUEUE_DEPTH + 2)
        begin
            post(pick_tag(), FIELD_TIME_W'($urandom_range(0, 60)));
        end
        tick(sent_time + FIELD_TIME_W'($urandom_range(20, 40)));

        // Random bursts, each leaning toward filling, mixing, draining or
        // crowding equal due times, some of them without any idle cycles.
        while (items_sent < ITEM_TARGET)
        begin
            mode  = $urandom_range(0, 3);
            quiet = ($urandom_range(0, 3) == 0);
            len   = $urandom_range(4, 40);
            case (mode)
                0:       post_share = 90;
                1:       post_share = 55;
                2:       post_share = 25;
                default: post_share = 70;
            endcase
            repeat (len)
            begin
                if ($urandom_range(0, 99) < post_share)
                begin
                    post(pick_tag(), pick_delay(mode));
                end
                else
                begin
                    tick(pick_time());
                end
            end
        end
        quiet = 1'b0;
        item_valid <= 1'b0;

        // Let the checker catch up with the last item, drain every result,
        // then give the block time to show any result it should not make.
        @(posedge clk);
        while (owed_count != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && owed_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
src/tedq_pkg.sv
src/tedq_ram.sv
src/tedq_ctrl.sv
src/tedq_dp.sv
src/timed_event_delay_queue.sv
sim/tedq_checker.sv
sim/tb_top.sv
